// File: hw/rtl/vsb_pkg.sv
`default_nettype none
package vsb_pkg;

  typedef logic signed [31:0] word_t;
  typedef word_t [2:0] vec3_t;
  typedef logic signed [33:0] term_t;
  typedef term_t [2:0] term3_t;
  typedef logic [11:0][31:0] bone_row_t;

  // stage advance enables shared by the lanes
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic s4_en;
  } adv_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SKIN = 1'b1;

  localparam logic [3:0] CFG_BONE_COUNT = 4'd0;
  localparam logic [3:0] CFG_NORMALS    = 4'd1;

  localparam int ELEMS_PER_BONE    = 12;
  localparam int PACKED_INFLUENCES = 4;

  function automatic word_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/vertex_skinning_blend_top.sv
// Linear blend skinning, Q16.16, up to four bone influences per vertex. One item
// enters per cycle while in_ready is high, loads and vertices alike; a vertex's
// out_valid rises once it has passed through every stage in turn (read
// of the bone row, products, row sums with saturation, weighting, then blend into
// the output register). Each stage advances on its own, so bubbles
// close up and an item is taken while a result waits. Load items (operation 0)
// write one matrix element into every lane's copy of the bone store and give no
// result; a vertex may follow its loads in the very next cycle. Every lane holds a
// full copy of the store so all influences read their row in the same cycle. Bone
// entries never written read as undefined. Configuration writes are taken at any
// time (cfg_ready is tied high) but should only happen while the block is idle.
`default_nettype none
module vertex_skinning_blend_top import vsb_pkg::*; #(
  parameter int MAX_BONES  = 64,
  parameter int INFLUENCES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [5:0]  in_bone_slot,
  input  wire logic [3:0]  in_matrix_element,
  input  wire logic signed [31:0] in_matrix_value,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [31:0] in_norm_x,
  input  wire logic signed [31:0] in_norm_y,
  input  wire logic signed [31:0] in_norm_z,
  input  wire logic [31:0] in_packed_indices,
  input  wire logic [63:0] in_packed_weights,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_norm_x,
  output logic signed [31:0] out_norm_y,
  output logic signed [31:0] out_norm_z,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  // influences past the packed fields carry zero weight: no lane for them
  localparam int NL = (INFLUENCES < PACKED_INFLUENCES) ? INFLUENCES : PACKED_INFLUENCES;

  // config
  logic [6:0] bone_count_r;
  logic       normals_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bone_count_r <= '0;
      normals_r    <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BONE_COUNT: bone_count_r <= cfg_data[6:0];
        CFG_NORMALS:    normals_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage valids and advance chain
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4, en5;
  adv_t adv;

  assign en5 = !out_valid || out_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;
  assign adv = '{s1_en: en1, s2_en: en2, s3_en: en3, s4_en: en4};

  logic acc;
  assign acc = in_valid && in_ready;

  // load decode
  logic [7:0]    slot8;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  assign slot8   = {2'b00, in_bone_slot};
  assign wr_addr = slot8[AW-1:0];
  assign wr_en   = acc && (in_operation == OP_LOAD)
                   && (in_matrix_element < 4'(ELEMS_PER_BONE))
                   && ({1'b0, slot8} < 9'(MAX_BONES));

  // per influence decode at accept
  logic [7:0]    bidx   [NL];
  logic [AW-1:0] rd_addr[NL];
  logic [15:0]   wgt    [NL];
  logic          use_inf[NL];
  logic          any_w;

  always_comb begin
    any_w = 1'b0;
    for (int j = 0; j < NL; j++) begin
      bidx[j]    = in_packed_indices[8*j +: 8];
      rd_addr[j] = bidx[j][AW-1:0];
      wgt[j]     = in_packed_weights[16*j +: 16];
      use_inf[j] = (wgt[j] != 16'd0) && ({1'b0, bidx[j]} < {2'b00, bone_count_r})
                   && ({1'b0, bidx[j]} < 9'(MAX_BONES));
      if (wgt[j] != 16'd0) any_w = 1'b1;
    end
  end

  // stage 1 registers (alongside the store read)
  vec3_t       pos1_r, nrm1_r;
  logic [15:0] w1_r [NL];
  logic        u1_r [NL];
  logic        any1_r, any2_r, any3_r, any4_r;
  vec3_t       pos2_r, nrm2_r, pos3_r, nrm3_r, pos4_r, nrm4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= acc && (in_operation == OP_SKIN);
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pos1_r <= {in_pos_z, in_pos_y, in_pos_x};
      nrm1_r <= {in_norm_z, in_norm_y, in_norm_x};
      any1_r <= any_w;
      for (int j = 0; j < NL; j++) begin
        w1_r[j] <= wgt[j];
        u1_r[j] <= use_inf[j];
      end
    end
    if (en2) begin
      pos2_r <= pos1_r;
      nrm2_r <= nrm1_r;
      any2_r <= any1_r;
    end
    if (en3) begin
      pos3_r <= pos2_r;
      nrm3_r <= nrm2_r;
      any3_r <= any2_r;
    end
    if (en4) begin
      pos4_r <= pos3_r;
      nrm4_r <= nrm3_r;
      any4_r <= any3_r;
    end
  end

  // lanes: one store copy and one transform unit per influence
  term3_t tp [NL];
  term3_t tn [NL];

  for (genvar j = 0; j < NL; j++) begin : g_lane
    bone_row_t row;

    vsb_bone_store #(.MAX_BONES(MAX_BONES), .AW(AW)) u_store (
      .clk      (clk),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_elem  (in_matrix_element),
      .wr_data  (in_matrix_value),
      .rd_en    (en1),
      .rd_addr  (rd_addr[j]),
      .rd_row_r (row)
    );

    vsb_lane u_lane (
      .clk     (clk),
      .adv     (adv),
      .row     (row),
      .pos     (pos1_r),
      .nrm     (nrm1_r),
      .w       (w1_r[j]),
      .use_inf (u1_r[j]),
      .tp_r    (tp[j]),
      .tn_r    (tn[j])
    );
  end

  // stage 5: blend, pass-through, saturate
  logic signed [63:0] accp [3];
  logic signed [63:0] accn [3];
  word_t              op   [3];
  word_t              on   [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      accp[c] = '0;
      accn[c] = '0;
      for (int j = 0; j < NL; j++) begin
        accp[c] = accp[c] + 64'(tp[j][c]);
        accn[c] = accn[c] + 64'(tn[j][c]);
      end
      op[c] = any4_r ? sat32(accp[c]) : $signed(pos4_r[c]);
      on[c] = !normals_r ? '0 : (any4_r ? sat32(accn[c]) : $signed(nrm4_r[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en5) begin
      out_valid <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_pos_x  <= op[0];
      out_pos_y  <= op[1];
      out_pos_z  <= op[2];
      out_norm_x <= on[0];
      out_norm_y <= on[1];
      out_norm_z <= on[2];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/vsb_bone_store.sv
`default_nettype none
module vsb_bone_store import vsb_pkg::*; #(
  parameter int MAX_BONES = 64,
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [3:0]    wr_elem,
  input  wire logic [31:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output bone_row_t          rd_row_r
);

  // one word per bone, written one element at a time
  bone_row_t mem [MAX_BONES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][wr_elem] <= wr_data;
    end
    if (rd_en) begin
      rd_row_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/vsb_lane.sv
`default_nettype none
module vsb_lane import vsb_pkg::*; (
  input  wire logic        clk,
  input  wire adv_t        adv,
  input  wire bone_row_t   row,
  input  wire vec3_t       pos,
  input  wire vec3_t       nrm,
  input  wire logic [15:0] w,
  input  wire logic        use_inf,
  output term3_t           tp_r,
  output term3_t           tn_r
);

  // stage 2: products floored to Q16.16
  logic signed [47:0] pp_r [3][3];
  logic signed [47:0] pn_r [3][3];
  word_t              tr_r [3];
  logic [15:0]        w2_r, w3_r;
  logic               f2_r, f3_r;
  // stage 3: saturated transformed components
  word_t              xp_r [3];
  word_t              xn_r [3];

  logic signed [63:0] prod_p [3][3];
  logic signed [63:0] prod_n [3][3];
  logic signed [63:0] sum_p [3];
  logic signed [63:0] sum_n [3];
  logic signed [48:0] wp [3];
  logic signed [48:0] wn [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        prod_p[c][r] = $signed(row[r*3+c]) * $signed(pos[r]);
        prod_n[c][r] = $signed(row[r*3+c]) * $signed(nrm[r]);
      end
      sum_p[c] = 64'(pp_r[c][0]) + 64'(pp_r[c][1]) + 64'(pp_r[c][2]) + 64'(tr_r[c]);
      sum_n[c] = 64'(pn_r[c][0]) + 64'(pn_r[c][1]) + 64'(pn_r[c][2]);
      wp[c] = $signed(xp_r[c]) * $signed({1'b0, w3_r});
      wn[c] = $signed(xn_r[c]) * $signed({1'b0, w3_r});
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2_en) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          pp_r[c][r] <= prod_p[c][r][63:16];
          pn_r[c][r] <= prod_n[c][r][63:16];
        end
        tr_r[c] <= $signed(row[9+c]);
      end
      w2_r <= w;
      f2_r <= use_inf;
    end
    if (adv.s3_en) begin
      for (int c = 0; c < 3; c++) begin
        xp_r[c] <= sat32(sum_p[c]);
        xn_r[c] <= sat32(sum_n[c]);
      end
      w3_r <= w2_r;
      f3_r <= f2_r;
    end
    if (adv.s4_en) begin
      for (int c = 0; c < 3; c++) begin
        tp_r[c] <= f3_r ? wp[c][48:15] : '0;
        tn_r[c] <= f3_r ? wn[c][48:15] : '0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/vsb_checker.sv
`default_nettype none
module vsb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_pos_x,
  input wire logic [31:0] out_norm_x,
  input wire logic        cfg_ready
);

  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // a free output lets every stage move, so input is open
  a_flow: assert property (@(posedge clk) disable iff (!rst_n) out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("cfg_ready low");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_norm_x))
    else $error("stalled item changed");

endmodule

bind vertex_skinning_blend_top vsb_checker u_vsb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_pos_x  (out_pos_x),
  .out_norm_x (out_norm_x),
  .cfg_ready  (cfg_ready)
);
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;
  import vsb_pkg::*;

  // One input item as the sender presents it
  typedef struct {
    logic        op;
    logic [5:0]  slot;
    logic [3:0]  elem;
    logic [31:0] mval;
    logic [31:0] pos[3];
    logic [31:0] nrm[3];
    logic [31:0] idx;
    logic [63:0] wts;
  } item_t;

  // One skinned vertex: pos x,y,z then normal x,y,z
  typedef struct {
    logic [31:0] f[6];
  } vertex_out_t;

  // Scoreboard: keeps its own copy of the bone store and registers and
  // computes the skinned vertex for each accepted vertex item.
  class skin_scoreboard;
    int          bones[64*ELEMS_PER_BONE];
    int          bone_count;
    bit          normals_on;
    vertex_out_t skinned_q[$];
    int          errors;

    function new();
      bone_count = 0;
      normals_on = 1;
      errors     = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // one component of bone b's 3x3 part times v, plus translation if asked
    function longint bone_xform(int b, int c, longint v0, longint v1, longint v2, bit tr);
      longint s;
      s = 0;
      s += (longint'(bones[b*12 + 0*3 + c]) * v0) >>> 16;
      s += (longint'(bones[b*12 + 1*3 + c]) * v1) >>> 16;
      s += (longint'(bones[b*12 + 2*3 + c]) * v2) >>> 16;
      if (tr) s += longint'(bones[b*12 + 9 + c]);
      return clamp32(s);
    endfunction

    function void set_reg(logic [3:0] index, logic [7:0] data);
      if (index == CFG_BONE_COUNT) bone_count = data & 8'h7f;
      else if (index == CFG_NORMALS) normals_on = data[0];
    endfunction

    function void note_item(item_t it);
      longint p[3], n[3], ap[3], an[3], w;
      int b;
      bit any;
      vertex_out_t r;
      if (it.op == OP_LOAD) begin
        if (it.elem < ELEMS_PER_BONE) bones[it.slot*12 + it.elem] = it.mval;
        return;
      end
      any = 0;
      for (int c = 0; c < 3; c++) begin
        p[c] = longint'($signed(it.pos[c]));
        n[c] = longint'($signed(it.nrm[c]));
        ap[c] = 0;
        an[c] = 0;
      end
      for (int j = 0; j < PACKED_INFLUENCES; j++) begin
        w = longint'({48'b0, it.wts[16*j +: 16]});
        if (w == 0) continue;
        any = 1;
        b = it.idx[8*j +: 8];
        if (b >= bone_count || b >= 64) continue;
        for (int c = 0; c < 3; c++) begin
          ap[c] += (bone_xform(b, c, p[0], p[1], p[2], 1) * w) >>> 15;
          an[c] += (bone_xform(b, c, n[0], n[1], n[2], 0) * w) >>> 15;
        end
      end
      if (!any) begin
        ap = p;
        an = n;
      end
      for (int c = 0; c < 3; c++) begin
        r.f[c]   = 32'(clamp32(ap[c]));
        r.f[3+c] = normals_on ? 32'(clamp32(an[c])) : 32'd0;
      end
      skinned_q.push_back(r);
    endfunction

    function void check_result(logic [31:0] got[6]);
      vertex_out_t e;
      if (skinned_q.size() == 0) begin
        $display("%0t: unexpected result pos %h %h %h", $time, got[0], got[1], got[2]);
        errors++;
        return;
      end
      e = skinned_q.pop_front();
      for (int k = 0; k < 6; k++)
        if (got[k] !== e.f[k]) begin
          $display("%0t: field %0d expected %h actual %h", $time, k, e.f[k], got[k]);
          errors++;
        end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 3000;   // cycles with no handshake at all
  localparam int SETTLE     = 12;     // pipeline is five deep

  logic clk = 0;
  logic rst_n = 0;
  always #5 clk = ~clk;

  logic        in_valid = 0, in_ready;
  logic        in_operation = 0;
  logic [5:0]  in_bone_slot = 0;
  logic [3:0]  in_matrix_element = 0;
  logic signed [31:0] in_matrix_value = 0;
  logic signed [31:0] in_pos_x = 0, in_pos_y = 0, in_pos_z = 0;
  logic signed [31:0] in_norm_x = 0, in_norm_y = 0, in_norm_z = 0;
  logic [31:0] in_packed_indices = 0;
  logic [63:0] in_packed_weights = 0;
  logic        out_valid, out_ready = 0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_norm_x, out_norm_y, out_norm_z;
  logic        cfg_valid = 0, cfg_ready;
  logic [3:0]  cfg_index = 0;
  logic [7:0]  cfg_data = 0;

  vertex_skinning_blend_top dut (.*);

  skin_scoreboard sb = new();

  // sender pacing state
  int burst_left = 0;
  bit rx_free = 0;       // receiver never stalls while set

  // ---------------------------------------------------------------------------
  // Receiver: ready comes in runs of random length and level; a result is
  // checked at the edge where valid and ready were both high.
  // ---------------------------------------------------------------------------
  int rx_hold = 0;
  bit rx_level = 1;
  logic [31:0] got[6];
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got = '{out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z};
      sb.check_result(got);
    end
    if (rx_hold > 0) rx_hold--;
    else begin
      rx_hold  = $urandom_range(0, 12);
      rx_level = ($urandom_range(0, 2) != 0);
    end
    out_ready <= rx_free | rx_level;
  end

  // Watchdog: any handshake restarts the count
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks. Each is entered right after a rising edge and returns
  // right after one, so every input gets a single assignment per step.
  // ---------------------------------------------------------------------------
  task automatic send_item(item_t it);
    in_valid          <= 1;
    in_operation      <= it.op;
    in_bone_slot      <= it.slot;
    in_matrix_element <= it.elem;
    in_matrix_value   <= it.mval;
    in_pos_x  <= it.pos[0];
    in_pos_y  <= it.pos[1];
    in_pos_z  <= it.pos[2];
    in_norm_x <= it.nrm[0];
    in_norm_y <= it.nrm[1];
    in_norm_z <= it.nrm[2];
    in_packed_indices <= it.idx;
    in_packed_weights <= it.wts;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
  endtask

  // send with burst/gap pacing
  task automatic send_paced(item_t it);
    send_item(it);
    if (burst_left > 0) burst_left--;
    else begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(0, 15);
    end
  endtask

  // stop sending until every expected vertex is out, then let the pipe settle
  task automatic drain();
    in_valid <= 0;
    while (sb.skinned_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // the idle wait after the write keeps back-to-back writes apart
  task automatic write_reg(logic [3:0] index, logic [7:0] data);
    cfg_valid <= 1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_reg(index, data);
    @(posedge clk);
  endtask

  function automatic item_t load_item(int slot, int elem, logic [31:0] v);
    item_t it;
    it = '{default: '0, pos: '{0, 0, 0}, nrm: '{0, 0, 0}};
    it.op   = OP_LOAD;
    it.slot = 6'(slot);
    it.elem = 4'(elem);
    it.mval = v;
    return it;
  endfunction

  function automatic item_t vertex_item(logic [31:0] px, py, pz, nx, ny, nz,
                                        logic [31:0] idx, logic [63:0] wts);
    item_t it;
    it = '{default: '0, pos: '{px, py, pz}, nrm: '{nx, ny, nz}};
    it.op  = OP_SKIN;
    it.idx = idx;
    it.wts = wts;
    return it;
  endfunction

  // mostly modest Q16.16 values, sometimes any 32-bit pattern
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
    endcase
  endfunction

  // picks bones 0..15, 62 and 63, which the initial fill loads, or an invalid index 64..255
  function automatic logic [7:0] pick_bone();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(64, 255));
      1: return 8'($urandom_range(62, 63));
      default: return 8'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    logic [31:0] idx;
    logic [63:0] wts;
    if ($urandom_range(0, 9) < 3) begin
      // loads: a few land on the ignored elements 12..15
      it = load_item($urandom_range(0, 63),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 11),
                     rand_word());
      if ($urandom_range(0, 5) == 0) begin
        it.pos[0] = $urandom;     // vertex fields are don't-care on a load
        it.wts    = {$urandom, $urandom};
      end
      return it;
    end
    for (int j = 0; j < 4; j++) begin
      case ($urandom_range(0, 5))
        0: idx[8*j +: 8] = 8'($urandom_range(64, 255));
        1: idx[8*j +: 8] = (sb.bone_count > 0) ? 8'(sb.bone_count - 1) : 8'd0;
        default: idx[8*j +: 8] = pick_bone();
      endcase
      case ($urandom_range(0, 5))
        0: wts[16*j +: 16] = 0;
        1: wts[16*j +: 16] = 16'h8000;
        2: wts[16*j +: 16] = 16'hffff;
        default: wts[16*j +: 16] = 16'($urandom_range(0, 16'h3fff));
      endcase
    end
    if ($urandom_range(0, 15) == 0) wts = 0;
    if ($urandom_range(0, 15) == 0) wts = {$urandom, $urandom};
    return vertex_item(rand_word(), rand_word(), rand_word(),
                       rand_word(), rand_word(), rand_word(), idx, wts);
  endfunction

  // register settings per phase, extremes included
  int phase_bones[7]   = '{64, 0, 1, 16, 64, 63, 12};
  bit phase_normals[7] = '{1, 1, 0, 1, 0, 1, 0};

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    write_reg(CFG_BONE_COUNT, 64);

    // Fill bones 0..15, 62 and 63; vertices only read these.
    // Bone 62 is all max and bone 63 all min, for saturation cases.
    for (int s = 0; s < 64; s++)
      if (s < 16 || s >= 62)
        for (int e = 0; e < ELEMS_PER_BONE; e++)
          send_item(load_item(s, e, (s == 62) ? 32'h7fffffff :
                                    (s == 63) ? 32'h80000000 : rand_word()));

    // ---- directed part ----
    send_item(load_item(0, 12, 32'hdeadbeef));   // element beyond eleven: ignored
    send_item(load_item(0, 15, 32'h12345678));
    // all weights zero: pass through, extremes
    send_item(vertex_item(32'h7fffffff, 32'h80000000, 0,
                          32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h3e3e3e3e, 0));
    // full weight on the max bone, max inputs: saturate high
    send_item(vertex_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h3e3e3e3e, 64'hffffffffffffffff));
    // min bone against max and min inputs
    send_item(vertex_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h80000000, 32'h80000000, 32'h80000000,
                          32'h3f3f3f3f, 64'hffffffffffffffff));
    send_item(vertex_item(32'h80000000, 32'h80000000, 32'h80000000,
                          32'h80000000, 32'h80000000, 32'h80000000,
                          32'h3e3e3e3e, 64'hffffffffffffffff));
    // invalid indices with nonzero weights: result is zero
    send_item(vertex_item(32'h10000, 32'h10000, 32'h10000, 32'h10000, 0, 0,
                          32'hff40ff40, 64'h8000800080008000));
    // mixed: a zero weight on an invalid index, three valid
    send_item(vertex_item(32'h00018000, 32'hfffe0000, 32'h00000001,
                          32'h00010000, 32'hffff0000, 32'h0,
                          32'h0105ff02, 64'h4000_2000_0000_8000));
    // single influence in each slot
    for (int j = 0; j < 4; j++)
      send_item(vertex_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            32'h0a0b0c0d, 64'h8000 << (16*j)));
    drain();
    write_reg(CFG_BONE_COUNT, 0);
    // no valid bones: weighted vertex gives zero, zero weights still pass
    send_item(vertex_item(32'h7fffffff, 1, 2, 3, 4, 5, 0, 64'h0001000100010001));
    send_item(vertex_item(32'h7fffffff, 1, 2, 3, 4, 5, 0, 0));
    drain();

    // ---- random part, one register setting per phase ----
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_BONE_COUNT, 8'(phase_bones[ph]));
      write_reg(CFG_NORMALS, 8'(phase_normals[ph]));
      rx_free = (ph == 4);      // one phase with the receiver never stalling
      for (int k = 0; k < 25; k++) begin
        send_paced(rand_item());
        if (ph == 2 && k == 12) drain();   // sender waits for all results
      end
      drain();
    end

    rx_free = 0;
    drain();
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
